FILE: hdl/brr_pkg.sv
// Shared types and constants for the BRR ADPCM decoder.
package brr_pkg;

    // Predictor filter codes taken from header bits 3..2.
    typedef enum logic [1:0] {
        FILTER_NONE  = 2'd0,
        FILTER_ONE   = 2'd1,
        FILTER_TWO   = 2'd2,
        FILTER_THREE = 2'd3
    } filter_t;

    // Width of the predictor's internal arithmetic.
    localparam int CALC_W = 22;

    // Block layout: byte 0 is the header, bytes 1 to 8 carry nibbles.
    localparam logic [3:0] POS_HEADER = 4'd0;
    localparam logic [3:0] POS_FIRST  = 4'd1;
    localparam logic [3:0] POS_LAST   = 4'd8;

    // Shifts from this value upwards mask the nibble instead of scaling it.
    localparam logic [3:0] SHIFT_MASK_MIN = 4'd13;

    // Filter coefficients.
    localparam logic signed [CALC_W-1:0] COEF_15  = 22'sd15;
    localparam logic signed [CALC_W-1:0] COEF_61  = 22'sd61;
    localparam logic signed [CALC_W-1:0] COEF_115 = 22'sd115;
    localparam logic signed [CALC_W-1:0] COEF_13  = 22'sd13;

    // Base value of a negative nibble under a masking shift.
    localparam logic signed [CALC_W-1:0] MASKED_NEG = -22'sd2048;

    // Clamp limits of the 16-bit intermediate sample.
    localparam logic signed [CALC_W-1:0] CLAMP_MIN = -22'sd32768;
    localparam logic signed [CALC_W-1:0] CLAMP_MAX = 22'sd32767;

    // One decoded result as it travels to the output stage.
    typedef struct packed {
        logic signed [15:0] sample;
        logic               loop_flag;
        logic               end_of_sample;
        logic               run_last;
    } result_t;

endpackage

FILE: hdl/brr_in_if.sv
// Byte stream channel into the decoder.
interface brr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first;

    modport source (output valid, output data_byte, output first, input ready);
    modport sink   (input valid, input data_byte, input first, output ready);
endinterface

FILE: hdl/brr_out_if.sv
// Decoded sample channel out of the decoder.
interface brr_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;
    logic               loop_flag;
    logic               end_of_sample;
    logic               run_last;

    modport source (output valid, output sample, output loop_flag,
                    output end_of_sample, output run_last, input ready);
    modport sink   (input valid, input sample, input loop_flag,
                    input end_of_sample, input run_last, output ready);
endinterface

FILE: hdl/brr_adpcm_decoder_top.sv
// Top level of the BRR ADPCM decoder: byte register, sequencer and predictor.
// A header byte is consumed without emitting a sample; a data byte yields one sample per nibble,
// in turn, as the second sample needs the history written by the first through the predictor.
// Each sample appears on the output the cycle after it is computed; a new byte is
// taken in the cycle its predecessor finishes. Reset clears history, position and flags.
module brr_adpcm_decoder_top
(
    input  logic      clk,
    input  logic      rst_n,
    brr_in_if.sink    stream,
    brr_out_if.source samples
);

    // Byte register.
    logic             item_valid_reg;
    logic             item_valid_next;
    logic [7:0]       byte_reg;
    logic             first_reg;

    // Decoder state.
    logic             phase_reg;
    logic             phase_next;
    logic signed [14:0] h1_reg;
    logic signed [14:0] h1_next;
    logic signed [14:0] h2_reg;
    logic signed [14:0] h2_next;
    logic [3:0]       pos_reg;
    logic [3:0]       pos_next;
    logic [3:0]       shift_reg;
    logic [3:0]       shift_next;
    brr_pkg::filter_t filter_reg;
    brr_pkg::filter_t filter_next;
    logic             loop_reg;
    logic             loop_next;
    logic             end_reg;
    logic             end_next;
    logic             finished_reg;
    logic             finished_next;

    // Effective state once a pending start of sample is applied.
    logic             eff_first;
    logic             eff_finished;
    logic [3:0]       eff_pos;
    logic signed [14:0] eff_h1;
    logic signed [14:0] eff_h2;

    logic             emits;
    logic             step_en;
    logic             consume;
    logic             last;
    logic             out_free;
    logic [3:0]       nibble;
    logic signed [14:0] history_new;
    brr_pkg::result_t result;

    // A start of sample applies only in the first phase of a byte.
    always_comb
    begin
        eff_first    = first_reg && !phase_reg;
        eff_finished = eff_first ? 1'b0 : finished_reg;
        eff_pos      = eff_first ? brr_pkg::POS_HEADER : pos_reg;
        eff_h1       = eff_first ? '0 : h1_reg;
        eff_h2       = eff_first ? '0 : h2_reg;
    end

    // Step control: header and ignored bytes never wait for the output register.
    assign last    = (pos_reg >= brr_pkg::POS_LAST);
    assign emits   = item_valid_reg &&
                     (phase_reg || (!eff_finished && eff_pos != brr_pkg::POS_HEADER));
    assign step_en = item_valid_reg && (!emits || out_free);
    assign consume = step_en && (phase_reg || !emits);

    assign stream.ready = !item_valid_reg || consume;

    // High nibble first, low nibble in the second phase.
    assign nibble = phase_reg ? byte_reg[3:0] : byte_reg[7:4];

    brr_predict u_predict
    (
        .nibble        (nibble),
        .shift_amount  (shift_reg),
        .filter_select (filter_reg),
        .history_one   (eff_h1),
        .history_two   (eff_h2),
        .history_new   (history_new)
    );

    // Result going to the output register.
    always_comb
    begin
        result.sample        = {history_new, 1'b0};
        result.loop_flag     = loop_reg;
        result.end_of_sample = phase_reg && last && end_reg;
        result.run_last      = phase_reg;
    end

    brr_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step_en && emits),
        .push_data (result),
        .free      (out_free),
        .samples   (samples)
    );

    // Next state of the sequencer and the decoder state.
    always_comb
    begin
        item_valid_next = item_valid_reg;
        phase_next      = phase_reg;
        h1_next         = h1_reg;
        h2_next         = h2_reg;
        pos_next        = pos_reg;
        shift_next      = shift_reg;
        filter_next     = filter_reg;
        loop_next       = loop_reg;
        end_next        = end_reg;
        finished_next   = finished_reg;

        if (step_en)
        begin
            if (phase_reg)
            begin
                h2_next    = h1_reg;
                h1_next    = history_new;
                phase_next = 1'b0;
                if (last)
                begin
                    pos_next = brr_pkg::POS_HEADER;
                    if (end_reg)
                    begin
                        finished_next = 1'b1;
                    end
                end
                else
                begin
                    pos_next = pos_reg + 4'd1;
                end
            end
            else
            begin
                h1_next       = eff_h1;
                h2_next       = eff_h2;
                pos_next      = eff_pos;
                finished_next = eff_finished;
                if (!eff_finished)
                begin
                    if (eff_pos == brr_pkg::POS_HEADER)
                    begin
                        shift_next  = byte_reg[7:4];
                        filter_next = brr_pkg::filter_t'(byte_reg[3:2]);
                        loop_next   = byte_reg[1];
                        end_next    = byte_reg[0];
                        pos_next    = brr_pkg::POS_FIRST;
                    end
                    else
                    begin
                        h2_next    = eff_h1;
                        h1_next    = history_new;
                        phase_next = 1'b1;
                    end
                end
            end
        end

        if (stream.valid && stream.ready)
        begin
            item_valid_next = 1'b1;
        end
        else if (consume)
        begin
            item_valid_next = 1'b0;
        end
    end

    // Control and decoder state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            phase_reg      <= 1'b0;
            h1_reg         <= '0;
            h2_reg         <= '0;
            pos_reg        <= brr_pkg::POS_HEADER;
            shift_reg      <= '0;
            filter_reg     <= brr_pkg::FILTER_NONE;
            loop_reg       <= 1'b0;
            end_reg        <= 1'b0;
            finished_reg   <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            phase_reg      <= phase_next;
            h1_reg         <= h1_next;
            h2_reg         <= h2_next;
            pos_reg        <= pos_next;
            shift_reg      <= shift_next;
            filter_reg     <= filter_next;
            loop_reg       <= loop_next;
            end_reg        <= end_next;
            finished_reg   <= finished_next;
        end
    end

    // Byte payload register, loaded on each input transfer.
    always_ff @(posedge clk)
    begin
        if (stream.valid && stream.ready)
        begin
            byte_reg  <= stream.data_byte;
            first_reg <= stream.first;
        end
    end

    // The second sample phase only exists while a byte is held.
    a_phase_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> item_valid_reg)
        else $error("second sample phase without a held byte");

    // The block position never runs past the last data byte.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= brr_pkg::POS_LAST)
        else $error("block position out of range");

    // A first sample issued is always followed by the second sample phase.
    a_first_then_second: assert property (@(posedge clk) disable iff (!rst_n)
        (step_en && emits && !phase_reg) |=> phase_reg)
        else $error("second sample phase missing after first sample");

    // End of sample is only flagged on the second sample of a byte.
    a_end_on_second: assert property (@(posedge clk) disable iff (!rst_n)
        (samples.valid && samples.end_of_sample) |-> samples.run_last)
        else $error("end of sample on a first sample");

    // Output samples are always even.
    a_sample_even: assert property (@(posedge clk) disable iff (!rst_n)
        samples.valid |-> !samples.sample[0])
        else $error("odd output sample");

endmodule

FILE: hdl/brr_predict.sv
// Combinational BRR sample reconstruction: scale, filter, clamp and wrap.
module brr_predict
(
    input  logic [3:0]          nibble,
    input  logic [3:0]          shift_amount,
    input  brr_pkg::filter_t    filter_select,
    input  logic signed [14:0]  history_one,
    input  logic signed [14:0]  history_two,
    output logic signed [14:0]  history_new
);

    logic signed [brr_pkg::CALC_W-1:0] nib_ext;
    logic signed [brr_pkg::CALC_W-1:0] scaled;
    logic signed [brr_pkg::CALC_W-1:0] base;
    logic signed [brr_pkg::CALC_W-1:0] h1_ext;
    logic signed [brr_pkg::CALC_W-1:0] h2_ext;
    logic signed [brr_pkg::CALC_W-1:0] term_add;
    logic signed [brr_pkg::CALC_W-1:0] term_sub;
    logic signed [brr_pkg::CALC_W-1:0] sum;
    logic signed [15:0]                clamped;

    // Sign extension of the nibble and the history words.
    assign nib_ext = {{(brr_pkg::CALC_W-4){nibble[3]}}, nibble};
    assign h1_ext  = {{(brr_pkg::CALC_W-15){history_one[14]}}, history_one};
    assign h2_ext  = {{(brr_pkg::CALC_W-15){history_two[14]}}, history_two};

    // Scaling of the nibble by the header shift.
    assign scaled = nib_ext <<< shift_amount;

    always_comb
    begin
        if (shift_amount >= brr_pkg::SHIFT_MASK_MIN)
        begin
            base = nibble[3] ? brr_pkg::MASKED_NEG : '0;
        end
        else
        begin
            base = scaled >>> 1;
        end
    end

    // Prediction terms of the selected filter.
    always_comb
    begin
        term_add = '0;
        term_sub = '0;
        case (filter_select)
            brr_pkg::FILTER_NONE:
            begin
                term_add = '0;
                term_sub = '0;
            end
            brr_pkg::FILTER_ONE:
            begin
                term_add = (h1_ext * brr_pkg::COEF_15) >>> 4;
            end
            brr_pkg::FILTER_TWO:
            begin
                term_add = (h1_ext * brr_pkg::COEF_61) >>> 5;
                term_sub = (h2_ext * brr_pkg::COEF_15) >>> 4;
            end
            brr_pkg::FILTER_THREE:
            begin
                term_add = (h1_ext * brr_pkg::COEF_115) >>> 6;
                term_sub = (h2_ext * brr_pkg::COEF_13) >>> 4;
            end
            default:
            begin
                term_add = '0;
                term_sub = '0;
            end
        endcase
    end

    assign sum = base + term_add - term_sub;

    // Clamp to 16 bits, then keep the low 15 bits as the new history word.
    always_comb
    begin
        if (sum < brr_pkg::CLAMP_MIN)
        begin
            clamped = brr_pkg::CLAMP_MIN[15:0];
        end
        else if (sum > brr_pkg::CLAMP_MAX)
        begin
            clamped = brr_pkg::CLAMP_MAX[15:0];
        end
        else
        begin
            clamped = sum[15:0];
        end
    end

    assign history_new = clamped[14:0];

endmodule

FILE: hdl/brr_out_stage.sv
// Output register that holds one result until the sink takes it.
module brr_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  brr_pkg::result_t  push_data,
    output logic              free,
    brr_out_if.source         samples
);

    logic             valid_reg;
    logic             valid_next;
    brr_pkg::result_t data_reg;

    // The register can take a new result when empty or when its transfer completes.
    assign free = !valid_reg || samples.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (push)
        begin
            valid_next = 1'b1;
        end
        else if (samples.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg <= push_data;
        end
    end

    assign samples.valid         = valid_reg;
    assign samples.sample        = data_reg.sample;
    assign samples.loop_flag     = data_reg.loop_flag;
    assign samples.end_of_sample = data_reg.end_of_sample;
    assign samples.run_last      = data_reg.run_last;

endmodule
